>>> hdl/crc16_command_frame_builder_macros.svh
// Assertion macros shared by the checkers of the frame builder.
// Each macro expects a clock named clk in scope; CFB_ASSERT_NEXT also expects an active-low reset named rst_n.
`ifndef CRC16_COMMAND_FRAME_BUILDER_MACROS_SVH
`define CRC16_COMMAND_FRAME_BUILDER_MACROS_SVH

// Next-cycle implication, switched off while reset is low.
`define CFB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CFB_ASSERT_NEXT_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds across reset.
`define CFB_ASSERT_SAME_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/cfb_pkg.sv
package cfb_pkg;

  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 3;
  localparam int WORD_FIELDS   = 4;
  localparam int MAX_WORDS_DEF = 4;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CRC_W         = 16;

  localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'h80;
  localparam logic [CRC_W-1:0]  CRC_POLY             = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT             = 16'h0000;

endpackage

>>> hdl/cfb_in_if.sv
interface cfb_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         command_code;
  logic [2:0]         word_count;
  logic signed [31:0] word0;
  logic signed [31:0] word1;
  logic signed [31:0] word2;
  logic signed [31:0] word3;

  modport source (
    output valid, command_code, word_count, word0, word1, word2, word3,
    input  ready
  );
  modport sink (
    input  valid, command_code, word_count, word0, word1, word2, word3,
    output ready
  );
endinterface

>>> hdl/cfb_out_if.sv
interface cfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

>>> hdl/crc16_command_frame_builder.sv
// Command frame builder. Each input transaction becomes one frame, sent one byte per
// output transaction: the device address byte, the command byte, word_count payload
// words of 32 bits sent most significant byte first (word0 first), and a CRC-16 over
// all of those bytes (polynomial 0x1021, initial value zero, MSB first, no final xor),
// high byte first. last_byte marks the low CRC byte. A word_count above MAX_WORDS, or
// above the four word fields, is treated as the smaller of the two. A frame of n words
// is 4 + 4n bytes long, sent one byte per cycle while the output is not stalled, and
// a queued next frame follows straight after the last byte. From idle, a frame's first byte
// passes the queue, S_IDLE, S_ADDR and the output register. The byte sequencer sets that
// rate; the input side keeps accepting until its two-entry queue is full, so the source is
// stalled only while two frames wait behind the one on air. device_address (reset 0x80)
// must be written through cfg_we and cfg_wdata while idle; the block does not enforce it.
module crc16_command_frame_builder
  import cfb_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  cfb_in_if.sink            in_ch,
  cfb_out_if.source         out_ch
);

  // Only as many words as can ever be sent are held in the queue.
  localparam int STORED_WORDS = (MAX_WORDS < WORD_FIELDS) ? MAX_WORDS : WORD_FIELDS;
  localparam int ENTRY_W      = BYTE_W + COUNT_W + STORED_WORDS * WORD_W;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_not_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  logic [BYTE_W-1:0]  device_address;

  // Front end: takes input transactions, holds the address register and
  // clamps the word count.
  cfb_front #(
    .STORED_WORDS (STORED_WORDS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (in_ch),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .device_address (device_address)
  );

  // Short queue of pending frames so that each side can stall on its own.
  cfb_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back end: byte sequencer with running CRC and a registered output stage.
  cfb_back #(
    .STORED_WORDS (STORED_WORDS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .device_address (device_address),
    .q_not_empty    (q_not_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_ch         (out_ch)
  );

endmodule

>>> hdl/cfb_queue.sv
module cfb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/cfb_front.sv
module cfb_front
  import cfb_pkg::*;
#(
  parameter int STORED_WORDS = MAX_WORDS_DEF,
  parameter int ENTRY_W      = BYTE_W + COUNT_W + STORED_WORDS * WORD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [BYTE_W-1:0]  cfg_wdata,
  cfb_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               q_push,
  output logic [ENTRY_W-1:0] q_data,
  output logic [BYTE_W-1:0]  device_address
);

  localparam int PAY_W = STORED_WORDS * WORD_W;
  localparam logic [COUNT_W-1:0] WORD_CAP = COUNT_W'(STORED_WORDS);

  logic [BYTE_W-1:0]             device_address_r;
  logic [COUNT_W-1:0]            words_clamped;
  logic [WORD_FIELDS*WORD_W-1:0] all_words;

  assign in_ch.ready    = !q_full;
  assign q_push         = in_ch.valid && !q_full;
  assign device_address = device_address_r;

  // Counts above the stored word budget saturate to it.
  assign words_clamped = (in_ch.word_count > WORD_CAP) ? WORD_CAP : in_ch.word_count;

  // word0 sits at the top so that the back end can shift bytes out from the MSB.
  assign all_words = {in_ch.word0, in_ch.word1, in_ch.word2, in_ch.word3};
  assign q_data    = {in_ch.command_code, words_clamped,
                      all_words[WORD_FIELDS*WORD_W-1 -: PAY_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= DEVICE_ADDRESS_RESET;
    end else if (cfg_we) begin
      device_address_r <= cfg_wdata;
    end
  end

endmodule

>>> hdl/cfb_back.sv
module cfb_back
  import cfb_pkg::*;
#(
  parameter int STORED_WORDS = MAX_WORDS_DEF,
  parameter int ENTRY_W      = BYTE_W + COUNT_W + STORED_WORDS * WORD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [BYTE_W-1:0]  device_address,
  input  logic               q_not_empty,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               q_pop,
  cfb_out_if.source          out_ch
);

  localparam int PAY_W  = STORED_WORDS * WORD_W;
  localparam int LEFT_W = $clog2(4 * STORED_WORDS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_CMD,
    S_DATA,
    S_CRC_HI,
    S_CRC_LO
  } state_t;

  function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  state_t             state_r, state_nxt;
  logic [BYTE_W-1:0]  cmd_r, cmd_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               last_r, last_nxt;
  logic               can_emit;
  logic               load;
  logic [BYTE_W-1:0]  emit_byte;
  logic [BYTE_W-1:0]  q_cmd;
  logic [COUNT_W-1:0] q_words;
  logic [PAY_W-1:0]   q_pay;

  assign {q_cmd, q_words, q_pay} = q_data;
  assign can_emit = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = last_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pay_nxt       = pay_r;
    left_nxt      = left_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    load          = 1'b0;
    emit_byte     = device_address;

    if (can_emit) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        load = q_not_empty;
      end
      S_ADDR: begin
        emit_byte = device_address;
        if (can_emit) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        emit_byte = cmd_r;
        if (can_emit) begin
          state_nxt = (left_r == '0) ? S_CRC_HI : S_DATA;
        end
      end
      S_DATA: begin
        emit_byte = pay_r[PAY_W-1 -: BYTE_W];
        if (can_emit) begin
          pay_nxt  = pay_r << BYTE_W;
          left_nxt = left_r - 1'b1;
          if (left_r == LEFT_W'(1)) begin
            state_nxt = S_CRC_HI;
          end
        end
      end
      S_CRC_HI: begin
        emit_byte = crc_r[CRC_W-1 -: BYTE_W];
        if (can_emit) begin
          state_nxt = S_CRC_LO;
        end
      end
      S_CRC_LO: begin
        emit_byte = crc_r[BYTE_W-1:0];
        if (can_emit) begin
          state_nxt = S_IDLE;
          load      = q_not_empty;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (can_emit && state_r != S_IDLE) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      last_nxt      = (state_r == S_CRC_LO);
      if (state_r != S_CRC_HI && state_r != S_CRC_LO) begin
        crc_nxt = crc_add_byte(crc_r, emit_byte);
      end
    end

    if (load) begin
      state_nxt = S_ADDR;
      cmd_nxt   = q_cmd;
      pay_nxt   = q_pay;
      left_nxt  = LEFT_W'({q_words, 2'b00});
      crc_nxt   = CRC_INIT;
    end
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    pay_r      <= pay_nxt;
    left_r     <= left_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
  end

endmodule

>>> hdl/cfb_checker.sv
`include "crc16_command_frame_builder_macros.svh"

module cfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte
);

  // A byte waiting on a stalled sink stays put.
  `CFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_byte), "output byte changed while stalled")

  // Reset empties the output stage.
  `CFB_ASSERT_NEXT_ALWAYS(a_reset_out, !rst_n, !out_valid, "output valid straight after reset")

  // The queue is empty after reset, so input is accepted at once.
  `CFB_ASSERT_SAME_ALWAYS(a_reset_ready, rst_n && $past(!rst_n), in_ready, "input not ready after reset")

endmodule

bind crc16_command_frame_builder cfb_checker u_cfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .last_byte (out_ch.last_byte)
);
